[sv/isfd_pkg.sv]
// ----------------------------------------------------------------------------
// isfd_pkg
// Shared types, byte codes and helpers for the IMU serial frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package isfd_pkg;

  // Frame byte codes
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_RATE   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;
  localparam logic [7:0] TYPE_MAG    = 8'h54;

  // Byte position codes (position = index of the next expected byte)
  localparam logic [3:0] POS_HUNT  = 4'd0;
  localparam logic [3:0] POS_TYPE  = 4'd1;
  localparam logic [3:0] POS_DATA0 = 4'd2;
  localparam logic [3:0] POS_DATA5 = 4'd7;
  localparam logic [3:0] POS_CHECK = 4'd10;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FS_W    = 12;
  localparam int unsigned AXIS_W  = 28;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned NUM_PAY = 6;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACCEL_FS = 2'd0;
  localparam logic [1:0] CFG_RATE_FS  = 2'd1;
  localparam logic [1:0] CFG_ANGLE_FS = 2'd2;

  // Reset full-scale values
  localparam logic [FS_W-1:0] ACCEL_FS_RST = 12'd16;
  localparam logic [FS_W-1:0] RATE_FS_RST  = 12'd2000;
  localparam logic [FS_W-1:0] ANGLE_FS_RST = 12'd180;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  // Full-scale register set
  typedef struct packed {
    logic [FS_W-1:0] accel;
    logic [FS_W-1:0] rate;
    logic [FS_W-1:0] angle;
  } fs_set_t;

  // Completed frame handed from framer to scaler
  typedef struct packed {
    kind_t                           kind;
    logic [NUM_PAY-1:0][BYTE_W-1:0]  pay;
  } frame_t;

  // Map a latched type byte to the result kind (only meaningful for 0x51..0x53)
  function automatic kind_t type_to_kind(input logic [7:0] type_byte);
    kind_t k;
    k = KIND_ACCEL;
    case (type_byte)
      TYPE_RATE:  k = KIND_RATE;
      TYPE_ANGLE: k = KIND_ANGLE;
      default:    k = KIND_ACCEL;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[sv/isfd_in_if.sv]
// ----------------------------------------------------------------------------
// isfd_in_if
// Byte request channel into the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface isfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/isfd_out_if.sv]
// ----------------------------------------------------------------------------
// isfd_out_if
// Scaled sensor result channel out of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface isfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [27:0] axis_x;
  logic signed [27:0] axis_y;
  logic signed [27:0] axis_z;

  modport source (output valid, output kind, output axis_x, output axis_y,
                  output axis_z, input ready);
  modport sink   (input valid, input kind, input axis_x, input axis_y,
                  input axis_z, output ready);
endinterface

`default_nettype wire

[sv/isfd_cfg_if.sv]
// ----------------------------------------------------------------------------
// isfd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface isfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [11:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

[sv/isfd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// isfd_cfg_regs
// Full-scale registers for the three result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

module isfd_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  isfd_cfg_if.sink         cfg,
  output isfd_pkg::fs_set_t fs
);

  isfd_pkg::fs_set_t fs_r;
  isfd_pkg::fs_set_t fs_nxt;

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register decode; unused index is ignored
  always_comb begin
    fs_nxt = fs_r;
    if (cfg.valid) begin
      unique case (cfg.reg_index)
        isfd_pkg::CFG_ACCEL_FS: fs_nxt.accel = cfg.wdata;
        isfd_pkg::CFG_RATE_FS:  fs_nxt.rate  = cfg.wdata;
        isfd_pkg::CFG_ANGLE_FS: fs_nxt.angle = cfg.wdata;
        default:                fs_nxt       = fs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r.accel <= isfd_pkg::ACCEL_FS_RST;
      fs_r.rate  <= isfd_pkg::RATE_FS_RST;
      fs_r.angle <= isfd_pkg::ANGLE_FS_RST;
    end else begin
      fs_r <= fs_nxt;
    end
  end

  assign fs = fs_r;

endmodule

`default_nettype wire

[sv/isfd_framer.sv]
// ----------------------------------------------------------------------------
// isfd_framer
// Byte-at-a-time packet framer: header hunt, type check, running checksum,
// payload capture, and a frame register toward the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module isfd_framer (
  input  wire logic          clk,
  input  wire logic          rst_n,
  isfd_in_if.sink            in_ch,
  output logic               frm_valid,
  output isfd_pkg::frame_t   frm,
  input  wire logic          frm_ready
);

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [isfd_pkg::NUM_PAY-1:0][7:0] pay_r;
  logic        frm_valid_r;
  isfd_pkg::frame_t frm_r;
  logic        in_acc;
  logic        emit;
  logic [7:0]  b;

  assign in_ch.ready = !frm_valid_r || frm_ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  // Parser next state
  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    type_nxt = type_r;
    emit     = 1'b0;
    if (in_acc) begin
      if (pos_r == isfd_pkg::POS_HUNT || pos_r > isfd_pkg::POS_CHECK) begin
        pos_nxt = isfd_pkg::POS_HUNT;
        if (b == isfd_pkg::HEADER_BYTE) begin
          sum_nxt = b;
          pos_nxt = isfd_pkg::POS_TYPE;
        end
      end else if (pos_r == isfd_pkg::POS_TYPE) begin
        if (b >= isfd_pkg::TYPE_ACCEL && b <= isfd_pkg::TYPE_MAG) begin
          type_nxt = b;
          sum_nxt  = sum_r + b;
          pos_nxt  = isfd_pkg::POS_DATA0;
        end else begin
          pos_nxt = isfd_pkg::POS_HUNT;
        end
      end else if (pos_r == isfd_pkg::POS_CHECK) begin
        // checksum byte; magnetic packets never produce a result
        pos_nxt = isfd_pkg::POS_HUNT;
        emit    = (sum_r == b) && (type_r >= isfd_pkg::TYPE_ACCEL)
                  && (type_r <= isfd_pkg::TYPE_ANGLE);
      end else begin
        sum_nxt = sum_r + b;
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= isfd_pkg::POS_HUNT;
      sum_r  <= '0;
      type_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      type_r <= type_nxt;
    end
  end

  // Payload capture: data bytes 0..5 land in fixed slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < isfd_pkg::NUM_PAY; i++) begin
      if (in_acc && pos_r == isfd_pkg::POS_DATA0 + 4'(i)) begin
        pay_r[i] <= b;
      end
    end
  end

  // Frame register toward the scaler
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_valid_r <= 1'b0;
    end else if (emit) begin
      frm_valid_r <= 1'b1;
    end else if (frm_ready) begin
      frm_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      frm_r.kind <= isfd_pkg::type_to_kind(type_r);
      frm_r.pay  <= pay_r;
    end
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;

endmodule

`default_nettype wire

[sv/isfd_scaler.sv]
// ----------------------------------------------------------------------------
// isfd_scaler
// Multiplies the three raw axes by the kind's full scale (Q.15 result) and
// holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module isfd_scaler (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          frm_valid,
  input  wire isfd_pkg::frame_t  frm,
  output logic               frm_ready,
  input  wire isfd_pkg::fs_set_t fs,
  isfd_out_if.source         out_ch
);

  localparam int unsigned PROD_W = isfd_pkg::RAW_W + isfd_pkg::FS_W + 1;

  logic                            out_valid_r;
  logic [1:0]                      kind_r;
  logic signed [isfd_pkg::AXIS_W-1:0] ax_r, ay_r, az_r;
  logic [isfd_pkg::FS_W-1:0]       fs_sel;
  logic signed [isfd_pkg::RAW_W-1:0] raw_x, raw_y, raw_z;
  logic signed [PROD_W-1:0]        px, py, pz;
  logic signed [isfd_pkg::FS_W:0]  fs_s;

  assign frm_ready = !out_valid_r || out_ch.ready;

  // Full-scale select by kind
  always_comb begin
    unique case (frm.kind)
      isfd_pkg::KIND_ACCEL: fs_sel = fs.accel;
      isfd_pkg::KIND_RATE:  fs_sel = fs.rate;
      isfd_pkg::KIND_ANGLE: fs_sel = fs.angle;
      default:              fs_sel = '0;
    endcase
  end

  // Little-endian raw axes and exact products
  always_comb begin
    raw_x = $signed({frm.pay[1], frm.pay[0]});
    raw_y = $signed({frm.pay[3], frm.pay[2]});
    raw_z = $signed({frm.pay[5], frm.pay[4]});
    fs_s  = $signed({1'b0, fs_sel});
    px    = PROD_W'(raw_x) * PROD_W'(fs_s);
    py    = PROD_W'(raw_y) * PROD_W'(fs_s);
    pz    = PROD_W'(raw_z) * PROD_W'(fs_s);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frm_ready) begin
      out_valid_r <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) begin
      kind_r <= frm.kind;
      ax_r   <= px[isfd_pkg::AXIS_W-1:0];
      ay_r   <= py[isfd_pkg::AXIS_W-1:0];
      az_r   <= pz[isfd_pkg::AXIS_W-1:0];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.kind   = kind_r;
  assign out_ch.axis_x = ax_r;
  assign out_ch.axis_y = ay_r;
  assign out_ch.axis_z = az_r;

endmodule

`default_nettype wire

[sv/imu_serial_frame_decoder.sv]
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder
// Frames 11-byte IMU packets from a byte stream and emits scaled axes.
// ----------------------------------------------------------------------------
// Takes one received byte per clock (in_chan.ready stays high unless a
// finished frame is waiting behind a stalled output). A packet is 0x55, a type
// byte 0x51..0x54, eight data bytes and an 8-bit sum checksum. Accel, rate and
// angle packets with a good checksum produce one result, held first in the
// frame register and then, through the three 16x12 multipliers, in the output
// register. Axes are raw * full_scale in signed Q.15. Full-scale registers
// (index 0 accel, 1 rate, 2 angle) are to be written by the user through
// cfg_chan while no packet is in flight; the block itself does not enforce it.
`default_nettype none

module imu_serial_frame_decoder (
  input  wire logic    clk,
  input  wire logic    rst_n,
  isfd_in_if.sink      in_chan,
  isfd_out_if.source   out_chan,
  isfd_cfg_if.sink     cfg_chan
);

  isfd_pkg::fs_set_t fs;
  isfd_pkg::frame_t  frm;
  logic              frm_valid;
  logic              frm_ready;

  isfd_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_chan),
    .fs    (fs)
  );

  isfd_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready)
  );

  isfd_scaler u_scaler (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready),
    .fs        (fs),
    .out_ch    (out_chan)
  );

`ifndef NO_ASSERTIONS
  // A frame only appears on the cycle after a byte was accepted
  a_frm_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(frm_valid) |-> $past(in_chan.valid && in_chan.ready))
    else $error("frame register loaded without an input byte");

  // Blocked frame holds its contents
  a_frm_hold: assert property (@(posedge clk) disable iff (!rst_n)
    frm_valid && !frm_ready |=> frm_valid && $stable(frm))
    else $error("pending frame lost or changed while scaler stalled");

  // A frame taken by the scaler shows up as a result
  a_frm_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    frm_valid && frm_ready |=> out_chan.valid)
    else $error("frame taken but no result presented");

  // Byte intake stops while a frame is stuck behind the output
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    frm_valid && !frm_ready |-> !in_chan.ready)
    else $error("byte taken while frame register is blocked");
`endif

endmodule

`default_nettype wire

[tb/imu_serial_frame_decoder_test.sv]
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder_test
// Self-checking bench for the IMU serial frame decoder.
// ----------------------------------------------------------------------------
// A short table of hand-built packets runs first, with the readings that are
// obvious from the packet typed in. The rest of the byte stream is random:
// mostly well-formed packets with random payloads, plus line noise, bad type
// bytes, cut-off packets and bad checksums. Every byte is run through a local
// copy of the framing and scaling logic. Each reading that leaves the block is
// compared against the oldest predicted one. The full-scale registers are
// rewritten between phases, including zero and the maximum value.
// ----------------------------------------------------------------------------

module imu_serial_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CFG_UNUSED   = 2'd3;    // no register behind it
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned END_WAIT     = 1000;
  localparam int unsigned BYTE_TARGET  = 320;
  localparam int unsigned NUM_SETTINGS = 7;
  localparam int unsigned NUM_DIR      = 10;
  localparam logic [3:0][7:0] RAW_EXTREMES = {8'hFF, 8'h80, 8'h7F, 8'h00};

  // one scaled reading as it leaves the block
  typedef struct {
    isfd_pkg::kind_t    kind;
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [27:0] z;
  } reading_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} row_check_e;

  // hand-built packet: bytes, optional checksum fill-in and typed reading
  typedef struct packed {
    logic [3:0]       len;
    logic             fix_sum;
    row_check_e       check;
    isfd_pkg::kind_t  kind;
    logic [27:0]      x;
    logic [27:0]      y;
    logic [27:0]      z;
    logic [0:10][7:0] bytes;
  } dir_row_t;

  logic clk;
  logic rst_n;

  isfd_in_if  in_if ();
  isfd_out_if out_if ();
  isfd_cfg_if cfg_if ();

  imu_serial_frame_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // local copy of the parser state and full-scale registers
  logic [3:0]  dec_pos;
  logic [7:0]  dec_type;
  logic [7:0]  dec_sum;
  logic [7:0]  dec_data [isfd_pkg::NUM_PAY];
  logic [11:0] scale_accel;
  logic [11:0] scale_rate;
  logic [11:0] scale_angle;

  reading_t    pending_readings [$];

  int unsigned error_count;
  int unsigned bytes_sent;
  int unsigned framed_bytes;
  int unsigned readings_seen;
  int unsigned settings_used;
  int unsigned burst_left;
  int unsigned idle_cycles = 0;

  logic [15:0] stall_pattern = 16'hFFFF;
  logic [6:0]  stall_count   = '0;

  // Typed readings assume the reset full-scale values (16, 2000, 180).
  dir_row_t dir_rows [NUM_DIR] = '{
    // accel, raw +32767 / -32768 / 0
    '{4'd11, 1'b1, ROW_RESULT, isfd_pkg::KIND_ACCEL,
      28'd524272, -28'sd524288, 28'd0,
      '{8'h55, 8'h51, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00}},
    // rate, raw +1 / -1 / 0
    '{4'd11, 1'b1, ROW_RESULT, isfd_pkg::KIND_RATE,
      28'd2000, -28'sd2000, 28'd0,
      '{8'h55, 8'h52, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55,
        8'h00}},
    // angle, raw -32768 / +32767 / +1
    '{4'd11, 1'b1, ROW_RESULT, isfd_pkg::KIND_ANGLE,
      -28'sd5898240, 28'd5898060, 28'd180,
      '{8'h55, 8'h53, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00, 8'h12, 8'h34,
        8'h00}},
    // magnetic packet, good checksum: no reading
    '{4'd11, 1'b1, ROW_NONE, isfd_pkg::KIND_ACCEL, 28'd0, 28'd0, 28'd0,
      '{8'h55, 8'h54, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88,
        8'h00}},
    // accel with checksum off by one: no reading
    '{4'd11, 1'b0, ROW_NONE, isfd_pkg::KIND_ACCEL, 28'd0, 28'd0, 28'd0,
      '{8'h55, 8'h51, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
        8'hCB}},
    // header repeated as type byte is dropped, not taken as a new header
    '{4'd5, 1'b0, ROW_NONE, isfd_pkg::KIND_ACCEL, 28'd0, 28'd0, 28'd0,
      '{8'h55, 8'h55, 8'h51, 8'h10, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00}},
    // noise while hunting
    '{4'd4, 1'b0, ROW_PREDICT, isfd_pkg::KIND_ACCEL, 28'd0, 28'd0, 28'd0,
      '{8'h00, 8'hFF, 8'h54, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00}},
    // type bytes just below and above the valid range
    '{4'd4, 1'b0, ROW_NONE, isfd_pkg::KIND_ACCEL, 28'd0, 28'd0, 28'd0,
      '{8'h55, 8'h50, 8'h55, 8'h56, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00}},
    // mixed payload
    '{4'd11, 1'b1, ROW_PREDICT, isfd_pkg::KIND_ACCEL, 28'd0, 28'd0, 28'd0,
      '{8'h55, 8'h51, 8'h34, 8'h12, 8'h78, 8'h56, 8'hBC, 8'h9A, 8'hF0, 8'hDE,
        8'h00}},
    // header byte inside the payload
    '{4'd11, 1'b1, ROW_PREDICT, isfd_pkg::KIND_ACCEL, 28'd0, 28'd0, 28'd0,
      '{8'h55, 8'h53, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'h55,
        8'h00}}
  };

  // 125 MHz clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // raw little-endian int16 times full scale, Q.15
  function automatic logic signed [27:0] scaled_axis(input logic [7:0]  lo,
                                                     input logic [7:0]  hi,
                                                     input logic [11:0] fs);
    logic signed [16:0] raw;
    logic signed [28:0] prod;
    raw  = $signed({hi, lo});
    prod = raw * $signed({1'b0, fs});
    return prod[27:0];
  endfunction

  // advance the parser copy by one byte; returns 1 when a reading is due
  function automatic bit decode_rx_byte(input logic [7:0] b, output reading_t r);
    logic [11:0] fs;
    bit          hit;
    hit    = 1'b0;
    fs     = '0;
    r.kind = isfd_pkg::KIND_ACCEL;
    r.x    = '0;
    r.y    = '0;
    r.z    = '0;
    if (dec_pos == isfd_pkg::POS_HUNT || dec_pos > isfd_pkg::POS_CHECK) begin
      dec_pos = isfd_pkg::POS_HUNT;
      if (b == isfd_pkg::HEADER_BYTE) begin
        dec_sum = b;
        dec_pos = isfd_pkg::POS_TYPE;
      end
    end else if (dec_pos == isfd_pkg::POS_TYPE) begin
      // bad type drops back to hunting without looking at it as a header
      if (b >= isfd_pkg::TYPE_ACCEL && b <= isfd_pkg::TYPE_MAG) begin
        dec_type = b;
        dec_sum  = dec_sum + b;
        dec_pos  = isfd_pkg::POS_DATA0;
      end else begin
        dec_pos = isfd_pkg::POS_HUNT;
      end
    end else if (dec_pos < isfd_pkg::POS_CHECK) begin
      if (dec_pos <= isfd_pkg::POS_DATA5)
        dec_data[dec_pos - isfd_pkg::POS_DATA0] = b;
      dec_sum = dec_sum + b;
      dec_pos = dec_pos + 4'd1;
    end else begin
      // checksum byte
      dec_pos = isfd_pkg::POS_HUNT;
      if (dec_sum == b) begin
        hit = 1'b1;
        case (dec_type)
          isfd_pkg::TYPE_ACCEL: begin
            r.kind = isfd_pkg::KIND_ACCEL;
            fs     = scale_accel;
          end
          isfd_pkg::TYPE_RATE: begin
            r.kind = isfd_pkg::KIND_RATE;
            fs     = scale_rate;
          end
          isfd_pkg::TYPE_ANGLE: begin
            r.kind = isfd_pkg::KIND_ANGLE;
            fs     = scale_angle;
          end
          default: hit = 1'b0;
        endcase
        r.x = scaled_axis(dec_data[0], dec_data[1], fs);
        r.y = scaled_axis(dec_data[2], dec_data[3], fs);
        r.z = scaled_axis(dec_data[4], dec_data[5], fs);
      end
    end
    return hit;
  endfunction

  // one byte request, sent in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b, input bit typed);
    reading_t r;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
    if (decode_rx_byte(b, r) && !typed)
      pending_readings.push_back(r);
  endtask

  // register write request; valid is left high for back-to-back writes
  task automatic write_full_scale(input logic [1:0] idx, input logic [11:0] val);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      isfd_pkg::CFG_ACCEL_FS: scale_accel = val;
      isfd_pkg::CFG_RATE_FS:  scale_rate  = val;
      isfd_pkg::CFG_ANGLE_FS: scale_angle = val;
      default: ;
    endcase
  endtask

  // mostly good packets; some with bad type, cut short or bad checksum
  task automatic send_random_frame();
    logic [7:0]  frame [11];
    logic [7:0]  sum;
    int unsigned roll;
    int unsigned count;
    roll  = $urandom_range(0, 99);
    count = 11;
    sum   = '0;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    frame[0] = isfd_pkg::HEADER_BYTE;
    if (roll < 12) begin
      frame[1] = 8'($urandom);
      if ($urandom_range(0, 3) == 0)
        frame[1] = isfd_pkg::HEADER_BYTE;
      else if (frame[1] >= isfd_pkg::TYPE_ACCEL && frame[1] <= isfd_pkg::TYPE_MAG)
        frame[1] = frame[1] ^ 8'h80;
      count = 2;
    end else begin
      frame[1] = isfd_pkg::TYPE_ACCEL + 8'($urandom_range(0, 3));
      for (int i = 2; i < 10; i++)
        frame[i] = ($urandom_range(0, 3) == 0) ? RAW_EXTREMES[$urandom_range(0, 3)]
                                               : 8'($urandom);
      for (int i = 0; i < 10; i++)
        sum = sum + frame[i];
      frame[10] = ($urandom_range(0, 99) < 85) ? sum : sum ^ 8'($urandom_range(1, 255));
      if (roll < 20)
        count = $urandom_range(3, 10);
    end
    for (int i = 0; i < count; i++)
      send_byte(frame[i], 1'b0);
    framed_bytes += count;
  endtask

  // receiver stall pattern, reloaded each time the 7-bit stall counter wraps
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                   : (16'($urandom) | 16'h0001);
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    end
    stall_count   <= stall_count + 7'd1;
    out_if.ready  <= stall_pattern[0];
  end

  // compare each accepted reading with the oldest prediction
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: kind %0d x %0d y %0d z %0d", out_if.kind,
               out_if.axis_x, out_if.axis_y, out_if.axis_z);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_if.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_if.kind);
          error_count++;
        end
        if (out_if.axis_x !== want.x) begin
          $error("axis_x: expected %0d, got %0d", want.x, out_if.axis_x);
          error_count++;
        end
        if (out_if.axis_y !== want.y) begin
          $error("axis_y: expected %0d, got %0d", want.y, out_if.axis_y);
          error_count++;
        end
        if (out_if.axis_z !== want.z) begin
          $error("axis_z: expected %0d, got %0d", want.z, out_if.axis_z);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long without any request moving on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no request moved for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    reading_t    typed_reading;
    logic [7:0]  b;
    logic [7:0]  row_sum;
    logic [11:0] fs_a;
    logic [11:0] fs_r;
    logic [11:0] fs_g;
    int unsigned waited;

    in_if.valid      = 1'b0;
    in_if.rx_byte    = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = isfd_pkg::CFG_ACCEL_FS;
    cfg_if.wdata     = '0;
    out_if.ready     = 1'b1;
    rst_n            = 1'b0;

    error_count   = 0;
    bytes_sent    = 0;
    framed_bytes  = 0;
    readings_seen = 0;
    settings_used = 1;
    burst_left    = 0;
    dec_pos       = isfd_pkg::POS_HUNT;
    dec_type      = '0;
    dec_sum       = '0;
    for (int i = 0; i < isfd_pkg::NUM_PAY; i++)
      dec_data[i] = '0;
    scale_accel = isfd_pkg::ACCEL_FS_RST;
    scale_rate  = isfd_pkg::RATE_FS_RST;
    scale_angle = isfd_pkg::ANGLE_FS_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // hand-built packets at the reset full-scale values
    for (int i = 0; i < NUM_DIR; i++) begin
      row_sum = '0;
      for (int j = 0; j < dir_rows[i].len; j++) begin
        b = dir_rows[i].bytes[j];
        if (dir_rows[i].fix_sum && j == 10)
          b = row_sum;
        row_sum = row_sum + b;
        send_byte(b, dir_rows[i].check != ROW_PREDICT);
      end
      if (dir_rows[i].check == ROW_RESULT) begin
        typed_reading.kind = dir_rows[i].kind;
        typed_reading.x    = dir_rows[i].x;
        typed_reading.y    = dir_rows[i].y;
        typed_reading.z    = dir_rows[i].z;
        pending_readings.push_back(typed_reading);
      end
    end

    // random phases, each under its own full-scale setting
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      // finish any open packet, then let the pipeline empty
      while (dec_pos != isfd_pkg::POS_HUNT)
        send_byte(8'h00, 1'b0);
      in_if.valid <= 1'b0;
      burst_left = 0;
      while (pending_readings.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);

      case (p)
        0: begin
          fs_a = 12'd4095;
          fs_r = 12'd4095;
          fs_g = 12'd4095;
        end
        1: begin
          fs_a = 12'd0;
          fs_r = 12'd0;
          fs_g = 12'd0;
        end
        2: begin
          fs_a = 12'd1;
          fs_r = 12'd1;
          fs_g = 12'd1;
        end
        default: begin
          fs_a = 12'($urandom_range(1, 4095));
          fs_r = 12'($urandom_range(1, 4095));
          fs_g = 12'($urandom_range(1, 4095));
        end
      endcase
      write_full_scale(isfd_pkg::CFG_ANGLE_FS, fs_g);
      write_full_scale(CFG_UNUSED, 12'($urandom));
      write_full_scale(isfd_pkg::CFG_ACCEL_FS, fs_a);
      write_full_scale(isfd_pkg::CFG_RATE_FS, fs_r);
      cfg_if.valid <= 1'b0;
      settings_used++;

      framed_bytes = 0;
      while (framed_bytes < BYTE_TARGET / NUM_SETTINGS)
        send_random_frame();
    end

    // drain
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_readings.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d predicted readings never arrived", pending_readings.size());
      error_count++;
    end

    $display("Sent %0d bytes under %0d full-scale settings, checked %0d readings.",
             bytes_sent, settings_used, readings_seen);
    $display("Mismatches and missing or extra readings: %0d", error_count);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
